FILE: hdl/hmte_pkg.sv
`timescale 1ns / 1ps

package hmte_pkg;

    localparam int MAX_WINDOW  = 8;
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int FRAC_BITS   = 24;

    localparam int BYTES_W     = 32;
    localparam int TIME_W      = 32;
    localparam int RECIP_W     = 56;
    // quotient bits of time * 2^(FRAC_BITS-3) / bytes
    localparam int RECIP_QBITS = TIME_W + FRAC_BITS - 3;
    localparam int SUM_W       = RECIP_W + PTR_W;
    localparam int EST_W       = 40;
    localparam int SCALE_W     = 23;
    localparam int NUM_W       = SCALE_W + FRAC_BITS;
    localparam int ITER_W      = 6;
    localparam int WIN_W       = 4;
    localparam int CASE_W      = 2;

    localparam logic [WIN_W-1:0]   WIN_RESET = 4'd5;
    localparam logic [RECIP_W-1:0] RECIP_MAX = '1;
    localparam logic [EST_W-1:0]   EST_MAX   = '1;

    localparam logic [CASE_W-1:0] CASE_NONE = 2'd0;
    localparam logic [CASE_W-1:0] CASE_FILL = 2'd1;
    localparam logic [CASE_W-1:0] CASE_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_WRITE,
        S_SUM,
        S_PREP,
        S_DIV2,
        S_DONE
    } t_state;

    // n * 10^6 for the sample counts that can occur
    function automatic logic [SCALE_W-1:0] scale_of(input logic [CNT_W-1:0] n);
        logic [SCALE_W-1:0] v;
        case (n)
            4'd1:    v = 23'd1000000;
            4'd2:    v = 23'd2000000;
            4'd3:    v = 23'd3000000;
            4'd4:    v = 23'd4000000;
            4'd5:    v = 23'd5000000;
            4'd6:    v = 23'd6000000;
            4'd7:    v = 23'd7000000;
            4'd8:    v = 23'd8000000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/harmonic_mean_throughput_estimator_top.sv
`timescale 1ns / 1ps

// Harmonic-mean throughput estimator.
// Input stream (s_axis): one request per decision. tuser = 1 marks a start
// with no finished download; tdata carries segment_bytes and
// download_time_us of the download just finished.
// Output stream (m_axis): one result per request, estimate_bps in tdata,
// decision_case and saturated in tuser.
// Config: i_cfg_we writes window_len (4 bits, reset 5); write
// it only while no request is in flight.
// Flow: a start request goes from acceptance straight to the output
// register. A download request runs through bit-serial restoring
// reciprocal division (skipped for a zero byte count), a ring write, ring
// reads and accumulation of the n samples averaged (1..8), a set-up step,
// bit-serial restoring estimate division (skipped for a zero sum) and the
// output register. One request is worked at a time.
// Reset (synchronous, active low) clears the write pointer, sample count,
// controller and output valid, and loads window_len = 5. The ring itself
// is not cleared: only written entries are ever summed.
// Stall: the result waits in the output register; a new request may be
// taken and worked meanwhile, and it finishes once the register is free.
module harmonic_mean_throughput_estimator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] segment_bytes, [63:32] download_time_us
    input  logic        s_axis_tuser,   // [0] no_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [39:0] estimate_bps
    output logic [2:0]  m_axis_tuser,   // [1:0] decision_case, [2] saturated
    input  logic        i_cfg_we,
    input  logic [hmte_pkg::WIN_W-1:0] i_cfg_wdata
);
    import hmte_pkg::*;

    t_state r_state, n_state;

    // control
    logic [WIN_W-1:0]  r_win;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [CNT_W-1:0]  r_cnt_smp, n_cnt_smp;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic              r_rd_vld;
    logic              r_out_valid, n_out_valid;

    // datapath
    logic [BYTES_W-1:0] r_b, n_b;
    logic [TIME_W-1:0]  r_t, n_t;
    logic [BYTES_W-1:0] r_rem1, n_rem1;
    logic [RECIP_W-1:0] r_recip, n_recip;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CASE_W-1:0]  r_case, n_case;
    logic               r_sat, n_sat;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [SUM_W-1:0]   r_rem2, n_rem2;
    logic [NUM_W-1:0]   r_quo2, n_quo2;
    logic [EST_W-1:0]   r_out_est, n_out_est;
    logic [CASE_W-1:0]  r_out_case, n_out_case;
    logic               r_out_sat, n_out_sat;

    // sample ring
    logic [RECIP_W-1:0] mem_ring [MAX_WINDOW];
    logic [RECIP_W-1:0] r_rd_data;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic               wr_en;

    // divider steps
    logic [BYTES_W:0] rem_sh1, diff1;
    logic             ge1;
    logic [SUM_W:0]   rem_sh2, diff2;
    logic             ge2;

    logic [CNT_W-1:0] win_eff, cnt_new;
    logic             in_acc, out_free, quo_ovf;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_est;
    assign m_axis_tuser  = {r_out_sat, r_out_case};

    // one restoring step each
    assign rem_sh1 = {r_rem1, r_t[TIME_W-1]};
    assign diff1   = rem_sh1 - {1'b0, r_b};
    assign ge1     = (rem_sh1 >= {1'b0, r_b});
    assign rem_sh2 = {r_rem2, r_num[NUM_W-1]};
    assign diff2   = rem_sh2 - {1'b0, r_sum};
    assign ge2     = (rem_sh2 >= {1'b0, r_sum});

    // window register clamped to 1..MAX_WINDOW
    assign win_eff = (r_win == '0) ? CNT_W'(1) :
                     (r_win > WIN_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : CNT_W'(r_win);
    assign cnt_new = (r_cnt_smp < CNT_W'(MAX_WINDOW)) ? r_cnt_smp + CNT_W'(1) : r_cnt_smp;

    // newest first: entry wp-1, wp-2, ...
    assign rd_en   = (r_state == S_SUM) && (r_cnt < ITER_W'(r_n));
    assign rd_addr = r_wp - PTR_W'(1) - r_cnt[PTR_W-1:0];
    assign wr_en   = (r_state == S_WRITE);

    assign quo_ovf = |r_quo2[NUM_W-1:EST_W];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_ring[r_wp] <= r_recip;
        end
        if (rd_en) begin
            r_rd_data <= mem_ring[rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_cnt_smp   = r_cnt_smp;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_b         = r_b;
        n_t         = r_t;
        n_rem1      = r_rem1;
        n_recip     = r_recip;
        n_n         = r_n;
        n_case      = r_case;
        n_sat       = r_sat;
        n_sum       = r_sum;
        n_num       = r_num;
        n_rem2      = r_rem2;
        n_quo2      = r_quo2;
        n_out_est   = r_out_est;
        n_out_case  = r_out_case;
        n_out_sat   = r_out_sat;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_b     = s_axis_tdata[BYTES_W-1:0];
                    n_t     = s_axis_tdata[BYTES_W +: TIME_W];
                    n_rem1  = '0;
                    n_recip = '0;
                    n_cnt   = '0;
                    n_sat   = 1'b0;
                    if (s_axis_tuser) begin
                        n_quo2  = '0;
                        n_case  = CASE_NONE;
                        n_state = S_DONE;
                    end else if (s_axis_tdata[BYTES_W-1:0] == '0) begin
                        // zero byte count: reciprocal clips
                        n_recip = RECIP_MAX;
                        n_sat   = 1'b1;
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_DIV1;
                    end
                end
            end
            S_DIV1: begin
                n_t     = {r_t[TIME_W-2:0], 1'b0};
                n_rem1  = ge1 ? diff1[BYTES_W-1:0] : rem_sh1[BYTES_W-1:0];
                n_recip = {r_recip[RECIP_W-2:0], ge1};
                n_cnt   = r_cnt + ITER_W'(1);
                if (r_cnt == ITER_W'(RECIP_QBITS - 1)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_wp      = r_wp + PTR_W'(1);
                n_cnt_smp = cnt_new;
                n_n       = (cnt_new < win_eff) ? cnt_new : win_eff;
                n_case    = (cnt_new < win_eff) ? CASE_FILL : CASE_FULL;
                n_sum     = '0;
                n_cnt     = '0;
                n_state   = S_SUM;
            end
            S_SUM: begin
                if (r_rd_vld) begin
                    n_sum = r_sum + SUM_W'(r_rd_data);
                end
                n_cnt = r_cnt + ITER_W'(1);
                if (r_cnt == ITER_W'(r_n)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_num  = {scale_of(r_n), FRAC_BITS'(0)};
                n_rem2 = '0;
                n_cnt  = '0;
                if (r_sum == '0) begin
                    // every reciprocal zero (duration zero or tiny against bytes): forces the clipped estimate
                    n_quo2  = '1;
                    n_state = S_DONE;
                end else begin
                    n_quo2  = '0;
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                n_num  = {r_num[NUM_W-2:0], 1'b0};
                n_rem2 = ge2 ? diff2[SUM_W-1:0] : rem_sh2[SUM_W-1:0];
                n_quo2 = {r_quo2[NUM_W-2:0], ge2};
                n_cnt  = r_cnt + ITER_W'(1);
                if (r_cnt == ITER_W'(NUM_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_est   = quo_ovf ? EST_MAX : r_quo2[EST_W-1:0];
                    n_out_case  = r_case;
                    n_out_sat   = r_sat || quo_ovf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win       <= WIN_RESET;
            r_wp        <= '0;
            r_cnt_smp   <= '0;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_win <= i_cfg_wdata;
            end
            r_wp        <= n_wp;
            r_cnt_smp   <= n_cnt_smp;
            r_cnt       <= n_cnt;
            r_rd_vld    <= rd_en;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b        <= n_b;
        r_t        <= n_t;
        r_rem1     <= n_rem1;
        r_recip    <= n_recip;
        r_n        <= n_n;
        r_case     <= n_case;
        r_sat      <= n_sat;
        r_sum      <= n_sum;
        r_num      <= n_num;
        r_rem2     <= n_rem2;
        r_quo2     <= n_quo2;
        r_out_est  <= n_out_est;
        r_out_case <= n_out_case;
        r_out_sat  <= n_out_sat;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_smp <= CNT_W'(MAX_WINDOW))
        else $error("sample count beyond window depth");

    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |=> r_wp == PTR_W'($past(r_wp) + PTR_W'(1)))
        else $error("write pointer did not advance by one");

    a_rem1_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV1 |-> r_rem1 < r_b)
        else $error("reciprocal remainder not below divisor");

    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SUM |-> (r_n != '0) && (r_n <= r_cnt_smp))
        else $error("averaging over unwritten or no samples");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_case == CASE_NONE |-> r_out_est == '0 && !r_out_sat)
        else $error("start result not all zero");

endmodule
